FILE: rtl/core/scnt_pkg.sv
// ----------------------------------------------------------------------------
// scnt_pkg
// Shared types, widths and constants for the scan cluster nearest-target block.
// ----------------------------------------------------------------------------
package scnt_pkg;

  localparam int MAX_BEAMS   = 4096;
  localparam int MAX_CLUSTER = 15;

  localparam int RANGE_W  = 17;
  localparam int IDX_W    = $clog2(MAX_BEAMS);
  localparam int CENTER_W = IDX_W + 1;
  localparam int COUNT_W  = $clog2(MAX_CLUSTER + 2);
  localparam int SUM_W    = RANGE_W + $clog2(MAX_CLUSTER + 1);
  localparam int PTS_W    = 4;
  localparam int ASTART_W = 19;
  localparam int ASTEP_W  = 14;
  localparam int ANGLE_W  = 27;
  localparam int APROD_W  = CENTER_W + ASTEP_W;

  // mean = (sum * recip) >> RECIP_SHIFT, exact for every sum below 2**SUM_W
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 26;
  localparam longint DivOne  = 64'd1 << RECIP_SHIFT;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [RANGE_W-1:0]  GAP_RESET    = 17'd60;
  localparam logic [PTS_W-1:0]    MIN_RESET    = 4'd3;
  localparam logic [PTS_W-1:0]    MAX_RESET    = 4'd8;
  localparam logic [RANGE_W-1:0]  LIMIT_RESET  = 17'd100000;
  localparam logic [ASTART_W-1:0] ASTART_RESET = 19'h4DBC1; // -205887
  localparam logic [ASTEP_W-1:0]  ASTEP_RESET  = 14'd382;

  typedef enum logic [2:0] {
    REG_GAP    = 3'd0,
    REG_MIN    = 3'd1,
    REG_MAX    = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_ASTART = 3'd4,
    REG_ASTEP  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_W-1:0]         gap;
    logic [PTS_W-1:0]           min_pts;
    logic [PTS_W-1:0]           max_pts;
    logic [RANGE_W-1:0]         limit;
    logic signed [ASTART_W-1:0] ang_start;
    logic [ASTEP_W-1:0]         ang_step;
  } cfg_t;

  typedef struct packed {
    logic               wr;
    logic [RANGE_W-1:0] value;
  } limit_upd_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic mul;
    logic cmp;
    logic ang;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic candidate;
    logic last;
    logic out_free;
  } status_t;

  // ceil(2**26 / n) for the point counts that can qualify
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = RECIP_W'(DivOne / 2);
      4'd3:    r = RECIP_W'((DivOne + 2) / 3);
      4'd4:    r = RECIP_W'(DivOne / 4);
      4'd5:    r = RECIP_W'((DivOne + 4) / 5);
      4'd6:    r = RECIP_W'((DivOne + 5) / 6);
      4'd7:    r = RECIP_W'((DivOne + 6) / 7);
      4'd8:    r = RECIP_W'(DivOne / 8);
      4'd9:    r = RECIP_W'((DivOne + 8) / 9);
      4'd10:   r = RECIP_W'((DivOne + 9) / 10);
      4'd11:   r = RECIP_W'((DivOne + 10) / 11);
      4'd12:   r = RECIP_W'((DivOne + 11) / 12);
      4'd13:   r = RECIP_W'((DivOne + 12) / 13);
      4'd14:   r = RECIP_W'((DivOne + 13) / 14);
      4'd15:   r = RECIP_W'((DivOne + 14) / 15);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/scnt_regs.sv
// ----------------------------------------------------------------------------
// scnt_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module scnt_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scnt_pkg::ADDR_W-1:0] paddr,
  input  logic [scnt_pkg::DATA_W-1:0] pwdata,
  output logic [scnt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output scnt_pkg::cfg_t             cfg,
  output scnt_pkg::limit_upd_t       limit_upd
);
  import scnt_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  assign limit_upd.wr    = wr_en && (idx == REG_LIMIT);
  assign limit_upd.value = pwdata[RANGE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap       <= GAP_RESET;
      cfg.min_pts   <= MIN_RESET;
      cfg.max_pts   <= MAX_RESET;
      cfg.limit     <= LIMIT_RESET;
      cfg.ang_start <= ASTART_RESET;
      cfg.ang_step  <= ASTEP_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_GAP:    cfg.gap       <= pwdata[RANGE_W-1:0];
        REG_MIN:    cfg.min_pts   <= pwdata[PTS_W-1:0];
        REG_MAX:    cfg.max_pts   <= pwdata[PTS_W-1:0];
        REG_LIMIT:  cfg.limit     <= pwdata[RANGE_W-1:0];
        REG_ASTART: cfg.ang_start <= pwdata[ASTART_W-1:0];
        REG_ASTEP:  cfg.ang_step  <= pwdata[ASTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAP:    prdata = DATA_W'(cfg.gap);
      REG_MIN:    prdata = DATA_W'(cfg.min_pts);
      REG_MAX:    prdata = DATA_W'(cfg.max_pts);
      REG_LIMIT:  prdata = DATA_W'(cfg.limit);
      REG_ASTART: prdata = DATA_W'(unsigned'(cfg.ang_start));
      REG_ASTEP:  prdata = DATA_W'(cfg.ang_step);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/scnt_ctrl.sv
// ----------------------------------------------------------------------------
// scnt_ctrl
// Per-word sequencer: step, optional mean/compare, result emission.
// ----------------------------------------------------------------------------
module scnt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              beam_valid,
  output logic              beam_stall,
  input  scnt_pkg::status_t status,
  output scnt_pkg::cmd_t    cmd
);
  import scnt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_STEP = 6'b000010,
    S_MUL  = 6'b000100,
    S_CMP  = 6'b001000,
    S_ANG  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  assign beam_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (beam_valid) begin
          cmd.accept = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (status.candidate)  state_next = S_MUL;
        else if (status.last)  state_next = S_ANG;
        else                   state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = status.last ? S_ANG : S_IDLE;
      end
      S_ANG: begin
        cmd.ang    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/scnt_dp.sv
// ----------------------------------------------------------------------------
// scnt_dp
// Cluster tracking, reciprocal mean, nearest-target keep and angle output.
// ----------------------------------------------------------------------------
module scnt_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  scnt_pkg::cmd_t                 cmd,
  output scnt_pkg::status_t              status,
  input  scnt_pkg::cfg_t                 cfg,
  input  scnt_pkg::limit_upd_t           limit_upd,
  input  logic [scnt_pkg::RANGE_W-1:0]   range_mm,
  input  logic                           range_valid,
  input  logic                           scan_last,
  output logic                           target_valid,
  input  logic                           target_stall,
  output logic                           target_found,
  output logic [scnt_pkg::RANGE_W-1:0]   target_distance_mm,
  output logic signed [scnt_pkg::ANGLE_W-1:0] target_angle_q16
);
  import scnt_pkg::*;

  localparam logic [IDX_W-1:0]   IDX_SAT   = IDX_W'(MAX_BEAMS - 1);
  localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_CLUSTER + 1);
  localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(MAX_CLUSTER);
  localparam int PROD_W = SUM_W + RECIP_W;

  // latched word
  logic [RANGE_W-1:0]  r_in;
  logic                v_in;
  logic                l_in;

  // per-scan state
  logic [IDX_W-1:0]    beam_index;
  logic                cluster_open;
  logic [IDX_W-1:0]    cluster_start_index;
  logic [RANGE_W-1:0]  previous_range;
  logic [SUM_W-1:0]    cluster_sum;
  logic [COUNT_W-1:0]  cluster_count;
  logic [RANGE_W-1:0]  best_distance;
  logic [CENTER_W-1:0] best_center_sum;
  logic                found_flag;

  // mean unit
  logic [SUM_W-1:0]    div_sum;
  logic [RECIP_W-1:0]  div_recip;
  logic [CENTER_W-1:0] div_center;
  logic [PROD_W-1:0]   div_prod;
  logic [APROD_W-1:0]  ang_prod;

  function automatic logic qual(input logic [COUNT_W-1:0] n,
                                input logic [PTS_W-1:0] mn,
                                input logic [PTS_W-1:0] mx);
    return (n >= COUNT_W'(2)) && (n >= COUNT_W'(mn)) && (n <= COUNT_W'(mx)) &&
           (n <= COUNT_TOP);
  endfunction

  logic [IDX_W-1:0]    prev_idx;
  logic [RANGE_W-1:0]  diff;
  logic                close1, q1, q2, open_a;
  logic                open_next;
  logic [IDX_W-1:0]    start_next;
  logic [SUM_W-1:0]    sum_next, base_sum;
  logic [COUNT_W-1:0]  count_next, base_count;
  logic [RANGE_W-1:0]  mean;
  logic signed [ANGLE_W:0] ang_sum;
  logic signed [ANGLE_W-1:0] ang_sat;

  always_comb begin
    prev_idx = (beam_index > cluster_start_index) ? beam_index - IDX_W'(1)
                                                  : cluster_start_index;
    diff   = (r_in > previous_range) ? r_in - previous_range : previous_range - r_in;
    close1 = cluster_open && (!v_in || (diff > cfg.gap));
    q1     = close1 && qual(cluster_count, cfg.min_pts, cfg.max_pts);
    open_a = cluster_open && !close1;

    base_count = open_a ? cluster_count : '0;
    base_sum   = open_a ? cluster_sum : '0;
    if (v_in) begin
      open_next  = 1'b1;
      start_next = open_a ? cluster_start_index : beam_index;
      count_next = (base_count < COUNT_SAT) ? base_count + COUNT_W'(1) : base_count;
      sum_next   = (base_count < COUNT_TOP) ? base_sum + SUM_W'(r_in) : base_sum;
    end else begin
      open_next  = open_a;
      start_next = cluster_start_index;
      count_next = cluster_count;
      sum_next   = cluster_sum;
    end
    // scan end closes the cluster at the current beam
    q2 = l_in && open_next && qual(count_next, cfg.min_pts, cfg.max_pts);
  end

  assign status.candidate = q1 || q2;
  assign status.last      = l_in;
  assign status.out_free  = !target_valid || !target_stall;

  assign mean = div_prod[RECIP_SHIFT +: RANGE_W];

  // angle = start + floor(center * step / 2), clamped to the output width
  always_comb begin
    ang_sum = (ANGLE_W+1)'(cfg.ang_start) +
              signed'({2'b00, ang_prod[APROD_W-1:1]});
    if (ang_sum[ANGLE_W] != ang_sum[ANGLE_W-1])
      ang_sat = ang_sum[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                 : {1'b0, {(ANGLE_W-1){1'b1}}};
    else
      ang_sat = ang_sum[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_in <= range_mm;
      v_in <= range_valid;
      l_in <= scan_last;
    end
    if (cmd.step) begin
      div_sum    <= q1 ? cluster_sum : sum_next;
      div_recip  <= recip(q1 ? cluster_count[3:0] : count_next[3:0]);
      div_center <= q1 ? CENTER_W'(cluster_start_index) + CENTER_W'(prev_idx)
                       : CENTER_W'(start_next) + CENTER_W'(beam_index);
    end
    if (cmd.mul) div_prod <= div_sum * div_recip;
    if (cmd.ang) ang_prod <= best_center_sum * cfg.ang_step;
    if (cmd.emit) begin
      target_found       <= found_flag;
      target_distance_mm <= best_distance;
      target_angle_q16   <= found_flag ? ang_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index          <= '0;
      cluster_open        <= 1'b0;
      cluster_start_index <= '0;
      previous_range      <= '0;
      cluster_sum         <= '0;
      cluster_count       <= '0;
      best_distance       <= LIMIT_RESET;
      best_center_sum     <= '0;
      found_flag          <= 1'b0;
      target_valid        <= 1'b0;
    end else begin
      if (target_valid && !target_stall) target_valid <= 1'b0;
      if (limit_upd.wr && !found_flag) best_distance <= limit_upd.value;
      if (cmd.step) begin
        cluster_open        <= open_next;
        cluster_start_index <= start_next;
        cluster_sum         <= sum_next;
        cluster_count       <= count_next;
        if (v_in) previous_range <= r_in;
        if (!l_in && beam_index < IDX_SAT) beam_index <= beam_index + IDX_W'(1);
      end
      if (cmd.cmp && mean < best_distance) begin
        best_distance   <= mean;
        best_center_sum <= div_center;
        found_flag      <= 1'b1;
      end
      if (cmd.emit) begin
        target_valid        <= 1'b1;
        beam_index          <= '0;
        cluster_open        <= 1'b0;
        cluster_start_index <= '0;
        previous_range      <= '0;
        cluster_sum         <= '0;
        cluster_count       <= '0;
        best_distance       <= cfg.limit;
        best_center_sum     <= '0;
        found_flag          <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/scan_cluster_nearest_target_top.sv
// ----------------------------------------------------------------------------
// scan_cluster_nearest_target_top
// Sequence: a beam word is accepted in idle and applied in step; if it closes
//   a qualifying cluster, mul (reciprocal multiply) and cmp (compare against
//   the best mean) follow. On a scan's last beam, ang and emit come next; emit
//   registers the result word once any older target word has been taken.
// Flow: a new beam word is taken only once the sequence is back in idle.
// Reset (rst, synchronous): registers to defaults, per-scan state cleared.
// ----------------------------------------------------------------------------
module scan_cluster_nearest_target_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [scnt_pkg::ADDR_W-1:0]          paddr,
  input  logic [scnt_pkg::DATA_W-1:0]          pwdata,
  output logic [scnt_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  // beam words
  input  logic                                 beam_valid,
  output logic                                 beam_stall,
  input  logic [scnt_pkg::RANGE_W-1:0]         range_mm,
  input  logic                                 range_valid,
  input  logic                                 scan_last,
  // target words, one per scan
  output logic                                 target_valid,
  input  logic                                 target_stall,
  output logic                                 target_found,
  output logic [scnt_pkg::RANGE_W-1:0]         target_distance_mm,
  output logic signed [scnt_pkg::ANGLE_W-1:0]  target_angle_q16
);
  import scnt_pkg::*;

  cfg_t       cfg;
  limit_upd_t limit_upd;
  cmd_t       cmd;
  status_t    status;

  // register file; the user must write it only while no beam word is in flight (not enforced by the block)
  scnt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .limit_upd (limit_upd)
  );

  // sequencer: idle -> step -> [mul -> cmp] -> [ang -> emit]
  scnt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .beam_valid (beam_valid),
    .beam_stall (beam_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath; the result register decouples the output side so the next
  // scan starts while a target word waits to be taken
  scnt_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg                (cfg),
    .limit_upd          (limit_upd),
    .range_mm           (range_mm),
    .range_valid        (range_valid),
    .scan_last          (scan_last),
    .target_valid       (target_valid),
    .target_stall       (target_stall),
    .target_found       (target_found),
    .target_distance_mm (target_distance_mm),
    .target_angle_q16   (target_angle_q16)
  );

endmodule
